// ----- rtl/rfs_pkg.sv -----
// rollback_frame_store package: command and status codes, item types
// no dependencies
`default_nettype none
package rfs_pkg;
  localparam logic [2:0] CMD_MARK     = 3'd0;
  localparam logic [2:0] CMD_ROLLBACK = 3'd1;
  localparam logic [2:0] CMD_ADVANCE  = 3'd2;
  localparam logic [2:0] CMD_DEALLOC  = 3'd3;
  localparam logic [2:0] CMD_WRITE    = 3'd4;
  localparam logic [2:0] CMD_READ     = 3'd5;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_MARK = 3'd1;
  localparam logic [2:0] ST_ROLL = 3'd2;
  localparam logic [2:0] ST_ADV  = 3'd3;
  localparam logic [2:0] ST_HW   = 3'd4;

  localparam int NUM_REGS = 8;

  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] segment;
    logic [3:0] frame_count;
    logic [3:0] range_first;
    logic [3:0] range_last;
    logic [3:0] block_index;
    logic [9:0] byte_offset;
    logic [7:0] write_byte;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] read_byte;
    logic [3:0] current_frame;
    logic [3:0] oldest_frame;
  } rsp_t;
endpackage
`default_nettype wire

// ----- rtl/rfs_stream_if.sv -----
// valid/ready channel carrying one payload beat
// payload type given as a parameter
`default_nettype none
interface rfs_stream_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/rfs_ram.sv -----
// generic single-port synchronous ram, registered read
// no dependencies
`default_nettype none
module rfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- rtl/rollback_frame_store.sv -----
// rollback_frame_store top level: sequencer, ring state, two byte memories
// depends on rfs_pkg, rfs_stream_if, rfs_ram
//
// Commands arrive on the req channel, one result beat per command leaves on
// the rsp channel. Segment bounds are written through a plain write port
// (cfg_we, cfg_index, cfg_data); the user must do so only while the block
// is idle, as the block itself does not enforce it. One command at a time;
// a new one is taken once the result register is free. A byte read or write
// goes through S_BYTE and S_BYTE2. Advance passes S_BLK and S_CRD per block,
// dealloc S_BLK alone per block. Mark copies each block n times, reading each
// byte in S_CRD and writing it in S_CWR through single-port memories;
// rollback copies each block once the same way. Reset (rst, synchronous)
// clears ring heads, fills, counters and bounds; memory contents are
// undefined until written. If the receiver stalls, the result holds and no
// further command is accepted.
`default_nettype none
module rollback_frame_store #(
  parameter int NUM_BLOCKS = 16,
  parameter int BYTES_PER_BLOCK = 1024,
  parameter int MAX_SAVED = 15,
  parameter int COUNTER_MODULUS = 16,
  parameter int NUM_SEGMENTS = 4
) (
  input wire logic clk,
  input wire logic rst,
  rfs_stream_if.sink   req,
  rfs_stream_if.source rsp,
  input wire logic       cfg_we,
  input wire logic [2:0] cfg_index,
  input wire logic [3:0] cfg_data
);
  localparam int BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int OW = $clog2(BYTES_PER_BLOCK);
  localparam int SW = (MAX_SAVED > 1) ? $clog2(MAX_SAVED) : 1;
  localparam int FW = $clog2(MAX_SAVED + 1);
  localparam int CW = $clog2(COUNTER_MODULUS);
  localparam int CUR_DEPTH = NUM_BLOCKS * BYTES_PER_BLOCK;
  localparam int FRM_DEPTH = NUM_BLOCKS * MAX_SAVED * BYTES_PER_BLOCK;
  localparam int CAW = $clog2(CUR_DEPTH);
  localparam int FAW = $clog2(FRM_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BYTE = 4'd1;
  localparam logic [3:0] S_BYTE2 = 4'd2;
  localparam logic [3:0] S_BLK = 4'd3;
  localparam logic [3:0] S_CRD = 4'd4;
  localparam logic [3:0] S_CWR = 4'd5;
  localparam logic [3:0] S_DONE = 4'd6;
  localparam logic [3:0] S_OUT = 4'd7;

  logic [3:0] state;
  logic [3:0] bounds [rfs_pkg::NUM_REGS];
  logic [SW-1:0] head [NUM_BLOCKS];
  logic [FW-1:0] fill [NUM_BLOCKS];
  logic [CW-1:0] cur_cnt [NUM_SEGMENTS];
  logic [CW-1:0] old_cnt [NUM_SEGMENTS];

  rfs_pkg::req_t r;
  rfs_pkg::rsp_t out;
  logic [4:0] idx;
  logic [4:0] last;
  logic [BW-1:0] blk;
  logic [3:0] rep;
  logic [OW-1:0] off;
  logic [SW-1:0] slot;
  logic checked;
  logic [2:0] status;
  logic [7:0] rbyte;

  logic cur_we, frm_we;
  logic [CAW-1:0] cur_addr;
  logic [FAW-1:0] frm_addr;
  logic [7:0] cur_wd, frm_wd, cur_rd, frm_rd;

  rfs_ram #(.WIDTH(8), .DEPTH(CUR_DEPTH)) u_cur (
    .clk, .we(cur_we), .addr(cur_addr), .wdata(cur_wd), .rdata(cur_rd));
  rfs_ram #(.WIDTH(8), .DEPTH(FRM_DEPTH)) u_frm (
    .clk, .we(frm_we), .addr(frm_addr), .wdata(frm_wd), .rdata(frm_rd));

  logic seg_ok;
  logic [3:0] n;
  logic [BW-1:0] r_blk;
  logic [OW-1:0] r_off;
  logic [SW-1:0] wslot;
  logic [SW-1:0] rslot;
  logic [SW:0] hsum;
  logic [FW-1:0] fb;
  logic [SW-1:0] hb;
  logic [SW+FW:0] wsum;
  logic [SW+FW:0] rsum;
  logic [CW-1:0] cur_s, old_s;

  assign seg_ok = 32'(r.segment) < NUM_SEGMENTS;
  assign n = r.frame_count;
  assign r_blk = BW'(32'(r.block_index) % NUM_BLOCKS);
  assign r_off = OW'(32'(r.byte_offset) % BYTES_PER_BLOCK);
  assign fb = fill[blk];
  assign hb = head[blk];
  assign wsum = (SW+FW+1)'(hb) + (SW+FW+1)'(fb);
  assign wslot = (wsum >= (SW+FW+1)'(MAX_SAVED)) ? SW'(wsum - (SW+FW+1)'(MAX_SAVED))
                                                 : SW'(wsum);
  assign rsum = (SW+FW+1)'(hb) + (SW+FW+1)'(fb) - (SW+FW+1)'(n);
  assign rslot = (rsum >= (SW+FW+1)'(MAX_SAVED)) ? SW'(rsum - (SW+FW+1)'(MAX_SAVED))
                                                 : SW'(rsum);
  assign slot = (r.cmd == rfs_pkg::CMD_MARK) ? wslot : rslot;
  assign hsum = (SW+1)'(32'(hb) + 32'(n));
  assign cur_s = seg_ok ? cur_cnt[r.segment[$clog2(NUM_SEGMENTS > 1 ? NUM_SEGMENTS : 2)-1:0]] : '0;
  assign old_s = seg_ok ? old_cnt[r.segment[$clog2(NUM_SEGMENTS > 1 ? NUM_SEGMENTS : 2)-1:0]] : '0;

  logic [FAW-1:0] frm_base;
  assign frm_base = FAW'((32'(blk) * MAX_SAVED + 32'(slot)) * BYTES_PER_BLOCK);

  always_comb begin
    cur_we = 1'b0;
    frm_we = 1'b0;
    cur_addr = CAW'(32'(blk) * BYTES_PER_BLOCK + 32'(off));
    frm_addr = frm_base + FAW'(off);
    cur_wd = r.write_byte;
    frm_wd = cur_rd;
    if (state == S_BYTE) begin
      cur_addr = CAW'(32'(r_blk) * BYTES_PER_BLOCK + 32'(r_off));
      cur_we = (r.cmd == rfs_pkg::CMD_WRITE);
    end else if (state == S_CWR) begin
      if (r.cmd == rfs_pkg::CMD_MARK) begin
        frm_we = 1'b1;
      end else begin
        cur_we = 1'b1;
        cur_wd = frm_rd;
      end
    end
  end

  logic nfail;
  assign nfail = (r.cmd == rfs_pkg::CMD_MARK) ? (32'(n) > MAX_SAVED - 32'(fb))
                                              : (32'(n) > 32'(fb));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < rfs_pkg::NUM_REGS; i++) bounds[i] <= '0;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
      for (int i = 0; i < NUM_SEGMENTS; i++) begin
        cur_cnt[i] <= '0;
        old_cnt[i] <= '0;
      end
    end else begin
      if (cfg_we) bounds[cfg_index] <= cfg_data;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            r <= req.data;
            status <= rfs_pkg::ST_OK;
            rbyte <= '0;
            checked <= 1'b0;
            rep <= '0;
            off <= '0;
            if (req.data.cmd == rfs_pkg::CMD_WRITE || req.data.cmd == rfs_pkg::CMD_READ) begin
              state <= S_BYTE;
            end else if (32'(req.data.segment) >= NUM_SEGMENTS) begin
              state <= S_OUT;
            end else if (req.data.cmd == rfs_pkg::CMD_DEALLOC) begin
              idx <= {1'b0, req.data.range_first};
              last <= {1'b0, req.data.range_last};
              state <= S_BLK;
            end else if (req.data.cmd <= rfs_pkg::CMD_ADVANCE && req.data.frame_count != 0) begin
              idx <= {1'b0, bounds[{req.data.segment, 1'b0}]};
              last <= {1'b0, bounds[{req.data.segment, 1'b1}]};
              state <= S_BLK;
            end else begin
              state <= S_OUT;
            end
            blk <= '0;
          end
        end
        S_BYTE: state <= S_BYTE2;
        S_BYTE2: begin
          if (r.cmd == rfs_pkg::CMD_READ) rbyte <= cur_rd;
          state <= S_OUT;
        end
        S_BLK: begin
          if (r.cmd == rfs_pkg::CMD_DEALLOC) begin
            if (idx > last) begin
              state <= S_DONE;
            end else begin
              head[BW'(32'(idx[3:0]) % NUM_BLOCKS)] <= '0;
              fill[BW'(32'(idx[3:0]) % NUM_BLOCKS)] <= '0;
              idx <= idx + 5'd1;
            end
          end else if (idx > last && checked) begin
            state <= S_DONE;
          end else begin
            // an empty range still checks its first block
            blk <= BW'(32'(idx[3:0]) % NUM_BLOCKS);
            state <= S_CRD;
            off <= '0;
            rep <= '0;
          end
        end
        S_CRD: begin
          if (rep == '0 && off == '0 && nfail) begin
            status <= checked ? rfs_pkg::ST_HW :
                      (r.cmd == rfs_pkg::CMD_MARK) ? rfs_pkg::ST_MARK :
                      (r.cmd == rfs_pkg::CMD_ROLLBACK) ? rfs_pkg::ST_ROLL : rfs_pkg::ST_ADV;
            state <= S_OUT;
          end else if (idx > last) begin
            state <= S_DONE;
          end else if (r.cmd == rfs_pkg::CMD_ADVANCE) begin
            checked <= 1'b1;
            head[blk] <= (hsum >= (SW+1)'(MAX_SAVED)) ? SW'(hsum - (SW+1)'(MAX_SAVED))
                                                      : SW'(hsum);
            fill[blk] <= fb - FW'(n);
            idx <= idx + 5'd1;
            state <= S_BLK;
          end else begin
            checked <= 1'b1;
            state <= S_CWR;
          end
        end
        S_CWR: begin
          if (32'(off) == BYTES_PER_BLOCK - 1) begin
            off <= '0;
            if (r.cmd == rfs_pkg::CMD_MARK) begin
              fill[blk] <= fb + FW'(1);
              rep <= rep + 4'd1;
              if (rep + 4'd1 == n) begin
                idx <= idx + 5'd1;
                state <= S_BLK;
              end else begin
                state <= S_CRD;
              end
            end else begin
              fill[blk] <= fb - FW'(n);
              idx <= idx + 5'd1;
              state <= S_BLK;
            end
          end else begin
            off <= off + OW'(1);
            state <= S_CRD;
          end
        end
        S_DONE: begin
          case (r.cmd)
            rfs_pkg::CMD_MARK: cur_cnt[r.segment] <= CW'((32'(cur_s) + 32'(n)) % COUNTER_MODULUS);
            rfs_pkg::CMD_ROLLBACK: cur_cnt[r.segment] <= CW'((32'(cur_s) + COUNTER_MODULUS
                                    - 32'(n) % COUNTER_MODULUS) % COUNTER_MODULUS);
            rfs_pkg::CMD_ADVANCE: old_cnt[r.segment] <= CW'((32'(old_s) + 32'(n)) % COUNTER_MODULUS);
            default: begin
              cur_cnt[r.segment] <= '0;
              old_cnt[r.segment] <= '0;
            end
          endcase
          state <= S_OUT;
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // mid-copy states skip check; S_CRD with off!=0 only reads
  always_comb begin
    out.status = status;
    out.read_byte = rbyte;
    out.current_frame = 4'(cur_s);
    out.oldest_frame = 4'(old_s);
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.data = out;

  a_one_side: assert property (@(posedge clk) disable iff (rst) !(req.ready && rsp.valid))
    else $error("accept while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("result changed under stall");
  a_rd_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && r.cmd != rfs_pkg::CMD_READ |-> rsp.data.read_byte == 8'd0)
    else $error("read byte set on non-read");
endmodule
`default_nettype wire

// ----- test/tb_rollback_frame_store.sv -----
// testbench for rollback_frame_store: directed and random command streams with
// a scoreboard class that predicts every result beat; uses rfs_pkg, rfs_stream_if
`timescale 1ns / 100ps
module tb_rollback_frame_store;

  localparam int NBLK = 16;
  localparam int BPB = 1024;
  localparam int NSAVE = 15;
  localparam int CYCLE_LIMIT = 40000000;
  localparam logic [2:0] REG_SEG0_FIRST = 3'd0;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  class frame_store_scoreboard;
    logic [7:0] cur_mem [NBLK*BPB];
    bit         cur_ok [NBLK*BPB];
    logic [7:0] frm_mem [NBLK*NSAVE*BPB];
    bit         frm_ok [NBLK*NSAVE*BPB];
    int         head [NBLK];
    int         fill [NBLK];
    logic [3:0] cur_cnt [4];
    logic [3:0] old_cnt [4];
    logic [3:0] bounds [8];
    rfs_pkg::rsp_t pending_rsp [$];
    int         errors;
    int         beats_checked;

    function new();
      for (int i = 0; i < NBLK; i++) begin
        head[i] = 0;
        fill[i] = 0;
      end
      for (int s = 0; s < 4; s++) begin
        cur_cnt[s] = '0;
        old_cnt[s] = '0;
        bounds[2*s] = '0;
        bounds[2*s+1] = '0;
      end
      errors = 0;
      beats_checked = 0;
    endfunction

    function void set_bound(int idx, logic [3:0] v);
      bounds[idx] = v;
    endfunction

    function void copy_block(int dst, int src, bit to_frame);
      for (int k = 0; k < BPB; k++) begin
        if (to_frame) begin
          frm_mem[dst+k] = cur_mem[src+k];
          frm_ok[dst+k] = cur_ok[src+k];
        end else begin
          cur_mem[dst+k] = frm_mem[src+k];
          cur_ok[dst+k] = frm_ok[src+k];
        end
      end
    endfunction

    function logic [2:0] run_mark(int first, int last, int n);
      int slot;
      if (n > NSAVE - fill[first]) return rfs_pkg::ST_MARK;
      for (int b = first; b <= last; b++) begin
        if (n > NSAVE - fill[b]) return rfs_pkg::ST_HW;
        for (int j = 0; j < n; j++) begin
          slot = (head[b] + fill[b]) % NSAVE;
          copy_block((b*NSAVE + slot)*BPB, b*BPB, 1'b1);
          fill[b]++;
        end
      end
      return rfs_pkg::ST_OK;
    endfunction

    function logic [2:0] run_rollback(int first, int last, int n);
      int slot;
      if (n > fill[first]) return rfs_pkg::ST_ROLL;
      for (int b = first; b <= last; b++) begin
        if (n > fill[b]) return rfs_pkg::ST_HW;
        fill[b] -= n;
        slot = (head[b] + fill[b]) % NSAVE;
        copy_block(b*BPB, (b*NSAVE + slot)*BPB, 1'b0);
      end
      return rfs_pkg::ST_OK;
    endfunction

    function logic [2:0] run_advance(int first, int last, int n);
      if (n > fill[first]) return rfs_pkg::ST_ADV;
      for (int b = first; b <= last; b++) begin
        if (n > fill[b]) return rfs_pkg::ST_HW;
        head[b] = (head[b] + n) % NSAVE;
        fill[b] -= n;
      end
      return rfs_pkg::ST_OK;
    endfunction

    function void note(rfs_pkg::req_t r);
      rfs_pkg::rsp_t e;
      int first, last, n, addr;
      first = bounds[2*r.segment];
      last = bounds[2*r.segment+1];
      n = r.frame_count;
      addr = r.block_index*BPB + r.byte_offset;
      e = '0;
      if (r.cmd == rfs_pkg::CMD_WRITE) begin
        cur_mem[addr] = r.write_byte;
        cur_ok[addr] = 1'b1;
      end else if (r.cmd == rfs_pkg::CMD_READ) begin
        e.read_byte = cur_mem[addr];
      end else if (r.cmd <= rfs_pkg::CMD_ADVANCE && n != 0) begin
        if (r.cmd == rfs_pkg::CMD_MARK) begin
          e.status = run_mark(first, last, n);
          if (e.status == rfs_pkg::ST_OK) cur_cnt[r.segment] = cur_cnt[r.segment] + 4'(n);
        end else if (r.cmd == rfs_pkg::CMD_ROLLBACK) begin
          e.status = run_rollback(first, last, n);
          if (e.status == rfs_pkg::ST_OK) cur_cnt[r.segment] = cur_cnt[r.segment] - 4'(n);
        end else begin
          e.status = run_advance(first, last, n);
          if (e.status == rfs_pkg::ST_OK) old_cnt[r.segment] = old_cnt[r.segment] + 4'(n);
        end
      end else if (r.cmd == rfs_pkg::CMD_DEALLOC) begin
        for (int b = r.range_first; b <= r.range_last; b++) begin
          head[b] = 0;
          fill[b] = 0;
        end
        cur_cnt[r.segment] = '0;
        old_cnt[r.segment] = '0;
      end
      e.current_frame = cur_cnt[r.segment];
      e.oldest_frame = old_cnt[r.segment];
      pending_rsp.push_back(e);
    endfunction

    function void check(rfs_pkg::rsp_t a);
      rfs_pkg::rsp_t e;
      beats_checked++;
      if (pending_rsp.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", a);
        return;
      end
      e = pending_rsp.pop_front();
      if (a.status !== e.status || a.read_byte !== e.read_byte ||
          a.current_frame !== e.current_frame || a.oldest_frame !== e.oldest_frame) begin
        errors++;
        if (errors <= 10)
          $display("mismatch beat %0d: exp st=%0d rd=%h cur=%0d old=%0d act st=%0d rd=%h cur=%0d old=%0d",
                   beats_checked, e.status, e.read_byte, e.current_frame, e.oldest_frame,
                   a.status, a.read_byte, a.current_frame, a.oldest_frame);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int cycles = 0;
  int sent = 0;
  frame_store_scoreboard sb = new();

  rfs_stream_if #(.payload_t(rfs_pkg::req_t)) req_if (clk);
  rfs_stream_if #(.payload_t(rfs_pkg::rsp_t)) rsp_if (clk);

  rollback_frame_store DUT (
    .clk(clk), .rst(rst), .req(req_if), .rsp(rsp_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (!rst && req_if.valid && req_if.ready) sb.note(req_if.data);
    if (!rst && rsp_if.valid && rsp_if.ready) sb.check(rsp_if.data);
  end

  // receiver: random stall bursts and one long hold-off
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rsp_if.ready <= 1'b0;
        stall = $urandom_range(1, 17) - 1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(rfs_pkg::req_t r);
    req_if.valid <= 1'b1;
    req_if.data <= r;
    do @(posedge clk); while (!req_if.ready);
    sent++;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
  endtask

  // a read of a byte never written turns into a write of that byte
  function automatic rfs_pkg::req_t guard_read(rfs_pkg::req_t r);
    if (r.cmd == rfs_pkg::CMD_READ && !sb.cur_ok[r.block_index*BPB + r.byte_offset])
      r.cmd = rfs_pkg::CMD_WRITE;
    return r;
  endfunction

  function automatic rfs_pkg::req_t make_req(logic [2:0] c, int s, int n, int blk, int off,
                                             int d);
    rfs_pkg::req_t r;
    r = '0;
    r.cmd = c;
    r.segment = 2'(s);
    r.frame_count = 4'(n);
    r.block_index = 4'(blk);
    r.byte_offset = 10'(off);
    r.write_byte = 8'(d);
    r.range_first = 4'($urandom_range(0, 15));
    r.range_last = 4'($urandom_range(0, 15));
    return guard_read(r);
  endfunction

  task automatic drain_and_config(logic [3:0] b [8]);
    req_if.valid <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_SEG0_FIRST + 3'(i);
      cfg_data <= b[i];
      sb.set_bound(i, b[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic rfs_pkg::req_t random_req();
    rfs_pkg::req_t r;
    int w, s, sz, first, last, n, blk;
    r = '0;
    r.segment = 2'($urandom_range(0, 3));
    r.range_first = 4'($urandom_range(0, 15));
    r.range_last = 4'($urandom_range(0, 15));
    r.block_index = 4'($urandom_range(0, 15));
    r.byte_offset = 10'($urandom_range(0, 1023));
    r.write_byte = 8'($urandom_range(0, 255));
    s = r.segment;
    first = sb.bounds[2*s];
    last = sb.bounds[2*s+1];
    sz = (last >= first) ? last - first + 1 : 0;
    w = $urandom_range(0, 99);
    if (w < 30) r.cmd = rfs_pkg::CMD_WRITE;
    else if (w < 58) r.cmd = rfs_pkg::CMD_READ;
    else if (w < 70) r.cmd = rfs_pkg::CMD_MARK;
    else if (w < 82) r.cmd = rfs_pkg::CMD_ROLLBACK;
    else if (w < 91) r.cmd = rfs_pkg::CMD_ADVANCE;
    else if (w < 96) r.cmd = rfs_pkg::CMD_DEALLOC;
    else r.cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE6 : CMD_SPARE7;
    if (sz > 0 && r.cmd inside {rfs_pkg::CMD_WRITE, rfs_pkg::CMD_READ} &&
        $urandom_range(0, 1) != 0)
      r.block_index = 4'($urandom_range(first, last));
    if (r.cmd == rfs_pkg::CMD_MARK) begin
      if (sz == 0) n = $urandom_range(0, 15);
      else if ($urandom_range(0, 9) == 0) n = 0;
      else if (sz == 1 && $urandom_range(0, 4) == 0) n = $urandom_range(1, 15);
      else n = $urandom_range(1, (4 / sz > 1) ? 4 / sz : 1);
    end else if (r.cmd == rfs_pkg::CMD_ROLLBACK || r.cmd == rfs_pkg::CMD_ADVANCE) begin
      n = $urandom_range(0, (sb.fill[first] + 1 > 15) ? 15 : sb.fill[first] + 1);
    end else begin
      n = $urandom_range(0, 15);
    end
    r.frame_count = 4'(n);
    if (r.cmd == rfs_pkg::CMD_READ && !sb.cur_ok[r.block_index*BPB + r.byte_offset]) begin
      for (int t = 0; t < 30; t++) begin
        blk = (sz > 0) ? $urandom_range(first, last) : $urandom_range(0, 15);
        if (sb.cur_ok[blk*BPB + (t * 37) % BPB]) begin
          r.block_index = 4'(blk);
          r.byte_offset = 10'((t * 37) % BPB);
          break;
        end
      end
    end
    return guard_read(r);
  endfunction

  initial begin
    logic [3:0] cfg_a [8] = '{4'd0, 4'd0, 4'd1, 4'd2, 4'd2, 4'd3, 4'd5, 4'd4};
    logic [3:0] cfg_b [8] = '{4'd15, 4'd15, 4'd0, 4'd15, 4'd7, 4'd8, 4'd9, 4'd9};
    logic [3:0] cfg_c [8] = '{4'd0, 4'd0, 4'd12, 4'd14, 4'd15, 4'd0, 4'd3, 4'd3};
    int counts [3] = '{110, 60, 97};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: drain_and_config(cfg_a);
        1: drain_and_config(cfg_b);
        default: drain_and_config(cfg_c);
      endcase
      if (ph == 0) begin
        send_item(make_req(rfs_pkg::CMD_WRITE, 0, 0, 0, 0, 8'h00));
        send_item(make_req(rfs_pkg::CMD_WRITE, 0, 0, 15, 1023, 8'hff));
        send_item(make_req(rfs_pkg::CMD_READ, 0, 0, 0, 0, 0));
        send_item(make_req(rfs_pkg::CMD_READ, 0, 0, 15, 1023, 0));
        send_item(make_req(rfs_pkg::CMD_MARK, 0, 0, 0, 5, 0));
        send_item(make_req(rfs_pkg::CMD_WRITE, 0, 0, 0, 5, 8'h5a));
        send_item(make_req(rfs_pkg::CMD_MARK, 0, 1, 0, 5, 0));
        send_item(make_req(rfs_pkg::CMD_WRITE, 0, 0, 0, 5, 8'ha5));
        send_item(make_req(rfs_pkg::CMD_ROLLBACK, 0, 1, 0, 5, 0));
        send_item(make_req(rfs_pkg::CMD_READ, 0, 0, 0, 5, 0));
        send_item(make_req(rfs_pkg::CMD_MARK, 0, 15, 0, 0, 0));
        send_item(make_req(rfs_pkg::CMD_MARK, 0, 1, 0, 0, 0));
        send_item(make_req(rfs_pkg::CMD_ROLLBACK, 0, 0, 0, 0, 0));
        send_item(make_req(rfs_pkg::CMD_ADVANCE, 0, 15, 0, 0, 0));
        send_item(make_req(rfs_pkg::CMD_ADVANCE, 0, 1, 0, 0, 0));
        send_item(make_req(rfs_pkg::CMD_ROLLBACK, 0, 1, 0, 0, 0));
        send_item(make_req(rfs_pkg::CMD_MARK, 1, 1, 0, 0, 0));
        send_item(make_req(rfs_pkg::CMD_MARK, 2, 1, 0, 0, 0));
        send_item(make_req(rfs_pkg::CMD_ROLLBACK, 2, 2, 0, 0, 0));
        send_item(make_req(rfs_pkg::CMD_MARK, 3, 7, 0, 0, 0));
        send_item(make_req(CMD_SPARE6, 1, 3, 0, 0, 0));
        send_item(make_req(CMD_SPARE7, 2, 3, 0, 0, 0));
        send_item(make_req(rfs_pkg::CMD_DEALLOC, 1, 0, 0, 0, 0));
      end
      for (int i = 0; i < counts[ph]; i++) begin
        if (ph == 0 && i == 40) hold_req = 1'b1;
        if (ph == 2 && i == counts[ph] - 40) quiet = 1'b1;
        send_item(random_req());
      end
    end
    req_if.valid <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (sb.pending_rsp.size() != 0) sb.errors++;
    $display("sent %0d commands over three segment layouts, checked %0d result beats",
             sent, sb.beats_checked);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/rfs_pkg.sv
rtl/rfs_stream_if.sv
rtl/rfs_ram.sv
rtl/rollback_frame_store.sv
test/tb_rollback_frame_store.sv
